@@ rtl/cfl_time_step_min_defines.svh @@
// Assertion helpers for the cfl_time_step_min block.
`ifndef CFL_TIME_STEP_MIN_DEFINES_SVH
`define CFL_TIME_STEP_MIN_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfl_time_step_min: assertion failed");

// Next-cycle implication, disabled during reset.
`define CTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfl_time_step_min: assertion failed");

`endif

@@ rtl/cflts_pkg.sv @@
package cflts_pkg;

   localparam int W32    = 32;
   localparam int SS_W   = 28;
   localparam int TS_W   = 25;
   localparam int CF_W   = 17;
   localparam int PROD_W = CF_W + W32;   // courant * spacing
   localparam int DEN_W  = W32 + 16;     // divisor aligned to the product scale

   localparam logic [CF_W-1:0] CF_RESET = 17'd32768;
   localparam logic [SS_W-1:0] SS_MAX   = '1;

   typedef struct packed {
      logic [W32-1:0]        temperature;
      logic signed [W32-1:0] velocity;
      logic [W32-1:0]        spacing;
      logic                  has_spacing;
      logic                  last_node;
   } req_type;

   typedef struct packed {
      logic [SS_W-1:0] acoustic_speed;
      logic [TS_W-1:0] time_step;
      logic            bad_divisor;
      logic            pass_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_SETUP,
      ST_CMP,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/cfl_time_step_min.sv @@
// Channel   Ports                               Direction  Moves
// request   req_valid, req_stall, req_item      in         one grid node per item
// response  rsp_valid, rsp_stall, rsp_item      out        one result per node
// config    csr_we, csr_wdata                   in         courant_factor, Q1.16
//
// Sequence: a node holds the engine through the bit-serial root with the Courant product
// alongside, the setup and compare states, restoring division and the finish state;
// it returns to idle before the next node is taken. The division is skipped without spacing,
// without a usable divisor, or when the product already reaches the divisor.
// Reset: synchronous, active high; courant_factor to 0.5, running minimum to 1.0.
// Stalls: a new node is taken while the last result waits; rsp_stall holds the post cycle.
`include "cfl_time_step_min_defines.svh"

module cfl_time_step_min #(
   parameter int FRAC_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cflts_pkg::req_type        req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cflts_pkg::rsp_type        rsp_item,
   input  logic                      csr_we,
   input  logic [cflts_pkg::CF_W-1:0] csr_wdata
);
   import cflts_pkg::*;

   // Square root of temperature << FRAC_BITS: one root bit per step.
   localparam int SQ_STEPS = (W32 + FRAC_BITS + 1) / 2;
   localparam int RAD_W    = 2 * SQ_STEPS;
   localparam int SQR_W    = SQ_STEPS + 1;        // stored partial remainder
   localparam int SQT_W    = SQ_STEPS + 3;        // trial remainder
   localparam int MIN_W    = FRAC_BITS + 1;       // holds 1.0
   localparam int CNT_MAX  = (SQ_STEPS > FRAC_BITS) ? SQ_STEPS : FRAC_BITS;
   localparam int CNT_W    = $clog2(CNT_MAX);

   localparam logic [MIN_W-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // architectural state
   logic [CF_W-1:0]    cf_ff;
   logic [MIN_W-1:0]   min_step_ff;
   logic               err_seen_ff;

   // captured node
   logic signed [W32-1:0] vel_ff;
   logic [W32-1:0]     sp_ff;
   logic               has_sp_ff;
   logic               last_ff;

   // square root
   logic [RAD_W-1:0]   rad_ff;
   logic [SQR_W-1:0]   srem_ff;
   logic [SQ_STEPS-1:0] root_ff;

   // serial multiply
   logic [CF_W-1:0]    cf_sr_ff;
   logic [PROD_W-1:0]  prod_ff;

   // division
   logic [DEN_W-1:0]   den_ff;
   logic [PROD_W-1:0]  rem_ff;
   logic [MIN_W-1:0]   quot_ff;
   logic               skip_ff;
   logic               err_hit_ff;
   logic [SS_W-1:0]    ss_ff;

   // combinational
   logic               req_take;
   logic               out_load;
   logic               sq_last;
   logic               div_last;
   logic [SQT_W-1:0]   sq_trial;
   logic [SQT_W-1:0]   sq_sub;
   logic               sq_ge;
   logic [SQT_W-1:0]   sq_rem_in;
   logic [SS_W-1:0]    ss_sat;
   logic signed [W32+1:0] div_sum;
   logic               div_bad;
   logic [PROD_W-1:0]  rem_sh;
   logic               rem_ge;
   logic               num_ge;
   logic [MIN_W-1:0]   min_in;
   logic               err_in;

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sq_last) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (skip_ff || num_ge) state_in = ST_FINISH;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Control outputs
   // ---------------------------------------------------------------
   always_comb begin
      req_stall = 1'b1;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_FINISH: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
            out_load  = 1'b0;
         end
      endcase
   end

   assign req_take = req_valid && !req_stall;
   assign sq_last  = (cnt_ff == CNT_W'(SQ_STEPS - 1));
   assign div_last = (cnt_ff == CNT_W'(FRAC_BITS - 1));

   // ---------------------------------------------------------------
   // Datapath step logic
   // ---------------------------------------------------------------
   // root step: bring down two radicand bits, try subtracting 4*root + 1
   assign sq_trial  = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_sub    = {1'b0, root_ff, 2'b01};
   assign sq_ge     = (sq_trial >= sq_sub);
   assign sq_rem_in = sq_ge ? (sq_trial - sq_sub) : sq_trial;

   // sound speed saturates to the 28-bit output range for wide fractions
   assign ss_sat = (64'(root_ff) > 64'(SS_MAX)) ? SS_MAX : SS_W'(root_ff);

   // divisor = sound speed + velocity, must be positive
   assign div_sum = $signed({{(W32 + 2 - SS_W){1'b0}}, ss_sat})
                  + $signed({{2{vel_ff[W32-1]}}, vel_ff});
   assign div_bad = div_sum[W32+1] || (div_sum == '0);

   // candidate saturates to 1.0 when the numerator reaches the divisor
   assign num_ge = (prod_ff >= PROD_W'(den_ff));

   // restoring division step
   assign rem_sh = {rem_ff[PROD_W-2:0], 1'b0};
   assign rem_ge = (rem_sh >= PROD_W'(den_ff));

   // minimum update; a skipped candidate is 1.0 and never wins
   assign min_in = (quot_ff < min_step_ff) ? quot_ff : min_step_ff;
   assign err_in = err_seen_ff || err_hit_ff;

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cf_ff        <= CF_RESET;
         min_step_ff  <= ONE_FIX;
         err_seen_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) cf_ff <= csr_wdata;

         if (req_take || (state_ff == ST_CMP)) cnt_ff <= '0;
         else if ((state_ff == ST_SQRT) || (state_ff == ST_DIV)) cnt_ff <= cnt_ff + 1'b1;

         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;

         if (out_load) begin
            min_step_ff <= last_ff ? ONE_FIX : min_in;
            err_seen_ff <= last_ff ? 1'b0 : err_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         vel_ff    <= req_item.velocity;
         sp_ff     <= req_item.spacing;
         has_sp_ff <= req_item.has_spacing;
         last_ff   <= req_item.last_node;
         rad_ff    <= RAD_W'({req_item.temperature, {FRAC_BITS{1'b0}}});
         srem_ff   <= '0;
         root_ff   <= '0;
         cf_sr_ff  <= cf_ff;
         prod_ff   <= '0;
      end

      if (state_ff == ST_SQRT) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         srem_ff <= SQR_W'(sq_rem_in);
         root_ff <= {root_ff[SQ_STEPS-2:0], sq_ge};
         // MSB-first shift-add multiply over the Courant bits
         if (cnt_ff < CNT_W'(CF_W)) begin
            cf_sr_ff <= {cf_sr_ff[CF_W-2:0], 1'b0};
            prod_ff  <= {prod_ff[PROD_W-2:0], 1'b0}
                      + (cf_sr_ff[CF_W-1] ? PROD_W'(sp_ff) : '0);
         end
      end

      if (state_ff == ST_SETUP) begin
         ss_ff      <= ss_sat;
         den_ff     <= {div_sum[W32-1:0], 16'b0};
         skip_ff    <= !has_sp_ff || div_bad;
         err_hit_ff <= has_sp_ff && div_bad;
      end

      if (state_ff == ST_CMP) begin
         rem_ff  <= prod_ff;
         quot_ff <= (skip_ff || num_ge) ? ONE_FIX : '0;
      end

      if (state_ff == ST_DIV) begin
         rem_ff  <= rem_ge ? (rem_sh - PROD_W'(den_ff)) : rem_sh;
         quot_ff <= {quot_ff[MIN_W-2:0], rem_ge};
      end

      if (out_load) begin
         rsp_ff.acoustic_speed <= ss_ff;
         rsp_ff.time_step      <= TS_W'(min_in);
         rsp_ff.bad_divisor    <= err_in;
         rsp_ff.pass_done      <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `CTS_ASSERT_NEXT(a_take_starts_root, clock, reset, req_take, state_ff == ST_SQRT)
   `CTS_ASSERT_NEXT(a_load_shows_valid, clock, reset, out_load, rsp_valid_ff)
   `CTS_ASSERT_NOW(a_div_rem_below_den, clock, reset, state_ff == ST_DIV,
                   rem_ff < PROD_W'(den_ff))
   `CTS_ASSERT_NOW(a_min_at_most_one, clock, reset, state_ff == ST_IDLE,
                   min_step_ff <= ONE_FIX)

endmodule
